### rtl/core/rlbc_pkg.sv
// Package for the RGB LED blink controller: operation, colour and phase codes, colour table.
package rlbc_pkg;

   // operation codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_FLASH  = 2'd1;
   localparam logic [1:0] OP_STEADY = 2'd2;
   localparam logic [1:0] OP_TIMED  = 2'd3;

   // colour codes
   localparam logic [2:0] COLOR_BLACK     = 3'd0;
   localparam logic [2:0] COLOR_WHITE     = 3'd1;
   localparam logic [2:0] COLOR_GREEN     = 3'd2;
   localparam logic [2:0] COLOR_BLUE      = 3'd3;
   localparam logic [2:0] COLOR_PURPLE    = 3'd4;
   localparam logic [2:0] COLOR_RED       = 3'd5;
   localparam logic [2:0] COLOR_NONE      = 3'd6;
   localparam logic [2:0] COLOR_NO_CHANGE = 3'd7;

   // phase codes
   localparam logic [1:0] PHASE_LIT      = 2'd0;
   localparam logic [1:0] PHASE_DARK     = 2'd1;
   localparam logic [1:0] PHASE_ONE_SHOT = 2'd2;

   // drive bits: bit 2 red, bit 1 green, bit 0 blue
   typedef logic [2:0] drive_type;

   // Map a colour onto the LED drive; none and no change keep the present drive.
   function automatic drive_type show_color(input logic [2:0] c, input drive_type cur);
      drive_type d;
      case (c)
         COLOR_BLACK:  d = 3'b000;
         COLOR_WHITE:  d = 3'b111;
         COLOR_GREEN:  d = 3'b010;
         COLOR_BLUE:   d = 3'b001;
         COLOR_PURPLE: d = 3'b101;
         COLOR_RED:    d = 3'b100;
         default:      d = cur;
      endcase
      return d;
   endfunction

endpackage

### rtl/core/rgb_led_blink_controller_top.sv
// Top level of the RGB LED blink controller: command/tick decode, pattern timer, result register.
//
// Each transfer on the req_ channel is either a tick or a command and yields exactly one
// result on the rsp_ channel carrying the LED drive and the running flag after that item.
// An item is processed in the cycle it is accepted: the pattern state and the result
// register both load at that edge, so one item per cycle is sustained. req_ready is high
// whenever the result register is empty or its result is being taken in the same cycle;
// the single result register is the only thing that can hold the input back.
module rgb_led_blink_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_color,
   input  logic [15:0] req_on_ticks,
   input  logic [15:0] req_off_ticks,
   input  logic [7:0]  req_blink_count,
   input  logic [15:0] req_level_or_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_red,
   output logic        rsp_green,
   output logic        rsp_blue,
   output logic        rsp_running
);

   // pattern state
   rlbc_pkg::drive_type led_drive_ff, led_drive_in;
   logic [1:0]          phase_ff, phase_in;
   logic                active_ff, active_in;
   logic [15:0]         ticks_left_ff, ticks_left_in;
   logic [15:0]         lit_ticks_ff, lit_ticks_in;
   logic [15:0]         dark_ticks_ff, dark_ticks_in;
   logic [2:0]          pattern_color_ff, pattern_color_in;
   logic [7:0]          blink_limit_ff, blink_limit_in;
   logic [8:0]          expiries_ff, expiries_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   rlbc_pkg::drive_type rsp_drive_ff;
   logic                rsp_running_ff;

   logic                req_xfer;
   logic [8:0]          expiry_count;
   logic [8:0]          expiry_limit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign expiry_count = expiries_ff + 9'd1;
   assign expiry_limit = {blink_limit_ff, 1'b0};

   // Work out the next pattern state for the item at the input
   always_comb begin
      led_drive_in     = led_drive_ff;
      phase_in         = phase_ff;
      active_in        = active_ff;
      ticks_left_in    = ticks_left_ff;
      lit_ticks_in     = lit_ticks_ff;
      dark_ticks_in    = dark_ticks_ff;
      pattern_color_in = pattern_color_ff;
      blink_limit_in   = blink_limit_ff;
      expiries_in      = expiries_ff;

      if (req_operation == rlbc_pkg::OP_TICK) begin
         if (active_ff) begin
            if (ticks_left_ff > 16'd1) begin
               ticks_left_in = ticks_left_ff - 16'd1;
            end else if (blink_limit_ff != 8'd0 && expiry_count == expiry_limit) begin
               // counted pattern finished: end dark
               expiries_in  = 9'd0;
               led_drive_in = 3'b000;
               active_in    = 1'b0;
            end else begin
               if (blink_limit_ff != 8'd0) begin
                  expiries_in = expiry_count;
               end
               case (phase_ff)
                  rlbc_pkg::PHASE_LIT: begin
                     led_drive_in  = 3'b000;
                     phase_in      = rlbc_pkg::PHASE_DARK;
                     ticks_left_in = dark_ticks_ff;
                  end
                  rlbc_pkg::PHASE_DARK: begin
                     led_drive_in  = rlbc_pkg::show_color(pattern_color_ff, led_drive_ff);
                     phase_in      = rlbc_pkg::PHASE_LIT;
                     ticks_left_in = lit_ticks_ff;
                  end
                  default: begin
                     // one-shot (and the unused phase code) goes dark and stops
                     led_drive_in = 3'b000;
                     active_in    = 1'b0;
                  end
               endcase
            end
         end
      end else if (req_color != rlbc_pkg::COLOR_NONE) begin
         expiries_in = 9'd0;
         case (req_operation)
            rlbc_pkg::OP_FLASH: begin
               blink_limit_in   = req_blink_count;
               pattern_color_in = req_color;
               lit_ticks_in     = req_on_ticks;
               dark_ticks_in    = req_off_ticks;
               phase_in         = rlbc_pkg::PHASE_LIT;
               led_drive_in     = rlbc_pkg::show_color(req_color, led_drive_ff);
               active_in        = 1'b1;
               ticks_left_in    = req_on_ticks;
            end
            rlbc_pkg::OP_STEADY: begin
               active_in    = 1'b0;
               led_drive_in = rlbc_pkg::show_color(
                  (req_level_or_time == 16'd0) ? rlbc_pkg::COLOR_BLACK : req_color,
                  led_drive_ff);
            end
            default: begin
               // timed on
               led_drive_in  = rlbc_pkg::show_color(req_color, led_drive_ff);
               phase_in      = rlbc_pkg::PHASE_ONE_SHOT;
               active_in     = 1'b1;
               ticks_left_in = req_level_or_time;
            end
         endcase
      end
   end

   // Advance the pattern state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         led_drive_ff     <= 3'b000;
         phase_ff         <= rlbc_pkg::PHASE_LIT;
         active_ff        <= 1'b0;
         ticks_left_ff    <= 16'd0;
         lit_ticks_ff     <= 16'd0;
         dark_ticks_ff    <= 16'd0;
         pattern_color_ff <= rlbc_pkg::COLOR_BLACK;
         blink_limit_ff   <= 8'd0;
         expiries_ff      <= 9'd0;
      end else if (req_xfer) begin
         led_drive_ff     <= led_drive_in;
         phase_ff         <= phase_in;
         active_ff        <= active_in;
         ticks_left_ff    <= ticks_left_in;
         lit_ticks_ff     <= lit_ticks_in;
         dark_ticks_ff    <= dark_ticks_in;
         pattern_color_ff <= pattern_color_in;
         blink_limit_ff   <= blink_limit_in;
         expiries_ff      <= expiries_in;
      end
   end

   // Hold the result until it is taken; load a new one on each input transfer
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_drive_ff   <= led_drive_in;
         rsp_running_ff <= active_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_red     = rsp_drive_ff[2];
   assign rsp_green   = rsp_drive_ff[1];
   assign rsp_blue    = rsp_drive_ff[0];
   assign rsp_running = rsp_running_ff;

endmodule

### dv/tb_rgb_led_blink_controller_top.sv
// Testbench for the RGB LED blink controller: directed and random items, checked against a predictor.
module tb_rgb_led_blink_controller_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic red;
      logic green;
      logic blue;
      logic running;
   } led_result_type;

   // clock, reset and block ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = rlbc_pkg::OP_TICK;
   logic [2:0]  req_color = rlbc_pkg::COLOR_BLACK;
   logic [15:0] req_on_ticks = '0;
   logic [15:0] req_off_ticks = '0;
   logic [7:0]  req_blink_count = '0;
   logic [15:0] req_level_or_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_red;
   logic        rsp_green;
   logic        rsp_blue;
   logic        rsp_running;

   // predicted LED state
   rlbc_pkg::drive_type led_now = '0;
   logic [1:0]  pat_phase = rlbc_pkg::PHASE_LIT;
   logic        pat_active = 1'b0;
   logic [15:0] ticks_remaining = '0;
   logic [15:0] lit_len = '0;
   logic [15:0] dark_len = '0;
   logic [2:0]  pat_colour = rlbc_pkg::COLOR_BLACK;
   logic [7:0]  blink_total = '0;
   logic [8:0]  expiry_count = '0;

   // drive for each shown colour, indexed by colour code
   rlbc_pkg::drive_type colour_lut [6] =
      '{3'b000, 3'b111, 3'b010, 3'b001, 3'b101, 3'b100};

   led_result_type led_expected [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_rsp_left = 0;

   rgb_led_blink_controller_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_color         (req_color),
      .req_on_ticks      (req_on_ticks),
      .req_off_ticks     (req_off_ticks),
      .req_blink_count   (req_blink_count),
      .req_level_or_time (req_level_or_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_running       (rsp_running)
   );

   always #5 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // Apply a colour to the predicted drive; none and no change keep it.
   function automatic rlbc_pkg::drive_type shown_drive(input logic [2:0] colour,
                                                       input rlbc_pkg::drive_type cur);
      return (colour <= rlbc_pkg::COLOR_RED) ? colour_lut[colour] : cur;
   endfunction

   // Advance the predicted state by one item and queue the expected result.
   task automatic predict_led(input logic [1:0] op, input logic [2:0] colour,
                              input logic [15:0] on_t, input logic [15:0] off_t,
                              input logic [7:0] count, input logic [15:0] lvl);
      logic finished;
      finished = 1'b0;
      if (op == rlbc_pkg::OP_TICK) begin
         if (pat_active) begin
            if (ticks_remaining > 16'd1) begin
               ticks_remaining--;
            end else begin
               // counted pattern: stop dark after twice the blink count
               if (blink_total != 8'd0) begin
                  expiry_count = expiry_count + 9'd1;
                  if (expiry_count == {blink_total, 1'b0}) begin
                     expiry_count = '0;
                     led_now = shown_drive(rlbc_pkg::COLOR_BLACK, led_now);
                     pat_active = 1'b0;
                     finished = 1'b1;
                  end
               end
               if (!finished) begin
                  case (pat_phase)
                     rlbc_pkg::PHASE_LIT: begin
                        led_now = shown_drive(rlbc_pkg::COLOR_BLACK, led_now);
                        pat_phase = rlbc_pkg::PHASE_DARK;
                        ticks_remaining = dark_len;
                     end
                     rlbc_pkg::PHASE_DARK: begin
                        led_now = shown_drive(pat_colour, led_now);
                        pat_phase = rlbc_pkg::PHASE_LIT;
                        ticks_remaining = lit_len;
                     end
                     default: begin
                        led_now = shown_drive(rlbc_pkg::COLOR_BLACK, led_now);
                        pat_active = 1'b0;
                     end
                  endcase
               end
            end
         end
      end else if (colour != rlbc_pkg::COLOR_NONE) begin
         expiry_count = '0;
         case (op)
            rlbc_pkg::OP_FLASH: begin
               blink_total = count;
               pat_colour = colour;
               lit_len = on_t;
               dark_len = off_t;
               pat_phase = rlbc_pkg::PHASE_LIT;
               led_now = shown_drive(colour, led_now);
               pat_active = 1'b1;
               ticks_remaining = on_t;
            end
            rlbc_pkg::OP_STEADY: begin
               pat_active = 1'b0;
               led_now = shown_drive((lvl == 16'd0) ? rlbc_pkg::COLOR_BLACK : colour,
                                     led_now);
            end
            default: begin
               led_now = shown_drive(colour, led_now);
               pat_phase = rlbc_pkg::PHASE_ONE_SHOT;
               pat_active = 1'b1;
               ticks_remaining = lvl;
            end
         endcase
      end
      led_expected.push_back('{led_now[2], led_now[1], led_now[0], pat_active});
   endtask

   // Offer one item, hold it until the transfer, then predict its result.
   task automatic send_item(input logic [1:0] op, input logic [2:0] colour,
                            input logic [15:0] on_t, input logic [15:0] off_t,
                            input logic [7:0] count, input logic [15:0] lvl);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_color         <= colour;
      req_on_ticks      <= on_t;
      req_off_ticks     <= off_t;
      req_blink_count   <= count;
      req_level_or_time <= lvl;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_led(op, colour, on_t, off_t, count, lvl);
   endtask

   // Tick with random content in the fields a tick ignores.
   task automatic send_tick();
      send_item(rlbc_pkg::OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom), 16'($urandom));
   endtask

   // Drop valid and wait for every outstanding result.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (led_expected.size() != 0);
   endtask

   // Receiver: long hold-off when asked, otherwise random stalls.
   always @(posedge clock) begin
      if (hold_rsp_left > 0) begin
         rsp_ready <= 1'b0;
         hold_rsp_left = hold_rsp_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic got, input logic want);
      if (got !== want)
         report_mismatch($sformatf("%s got %b want %b", name, got, want));
   endtask

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin : check_result
      led_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (led_expected.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = led_expected.pop_front();
            check_field("red", rsp_red, want.red);
            check_field("green", rsp_green, want.green);
            check_field("blue", rsp_blue, want.blue);
            check_field("running", rsp_running, want.running);
         end
      end
   end

   // Ticks with no pattern running change nothing.
   task automatic test_idle_ticks();
      send_item(rlbc_pkg::OP_TICK, rlbc_pkg::COLOR_NO_CHANGE, 16'hFFFF, 16'hFFFF, 8'hFF,
                16'hFFFF);
      send_item(rlbc_pkg::OP_TICK, rlbc_pkg::COLOR_BLACK, 16'h0000, 16'h0000, 8'h00,
                16'h0000);
   endtask

   // Steady lit and dark, ignored colour and unchanged colour.
   task automatic test_steady();
      send_item(rlbc_pkg::OP_STEADY, rlbc_pkg::COLOR_WHITE, 16'd0, 16'd0, 8'd0, 16'hFFFF);
      send_item(rlbc_pkg::OP_STEADY, rlbc_pkg::COLOR_NONE, 16'd0, 16'd0, 8'd0, 16'd0);
      send_item(rlbc_pkg::OP_STEADY, rlbc_pkg::COLOR_NO_CHANGE, 16'd5, 16'd5, 8'd5, 16'd1);
      send_item(rlbc_pkg::OP_STEADY, rlbc_pkg::COLOR_RED, 16'd0, 16'd0, 8'd0, 16'd0);
   endtask

   // One blink with zero-length phases: lit, dark, then stop.
   task automatic test_counted_flash();
      send_item(rlbc_pkg::OP_FLASH, rlbc_pkg::COLOR_GREEN, 16'd0, 16'd0, 8'd1, 16'd0);
      repeat (4) send_tick();
   endtask

   // Endless blinking, then a flash that keeps the drive at the widest lengths.
   task automatic test_endless_flash();
      send_item(rlbc_pkg::OP_FLASH, rlbc_pkg::COLOR_PURPLE, 16'd1, 16'd2, 8'd0, 16'd0);
      repeat (4) send_tick();
      send_item(rlbc_pkg::OP_FLASH, rlbc_pkg::COLOR_NO_CHANGE, 16'hFFFF, 16'hFFFF, 8'hFF,
                16'hFFFF);
   endtask

   // Timed on after a counted flash, and a zero duration.
   task automatic test_timed_on();
      send_item(rlbc_pkg::OP_FLASH, rlbc_pkg::COLOR_BLUE, 16'd1, 16'd1, 8'd2, 16'd0);
      send_tick();
      send_item(rlbc_pkg::OP_TIMED, rlbc_pkg::COLOR_RED, 16'd0, 16'd0, 8'd0, 16'd2);
      repeat (3) send_tick();
      send_item(rlbc_pkg::OP_TIMED, rlbc_pkg::COLOR_WHITE, 16'd0, 16'd0, 8'd0, 16'd0);
      send_tick();
   endtask

   // Counted pattern past 255 expiries, so the full expiry counter width is used.
   task automatic test_long_count();
      logic [7:0] count;
      count = 8'($urandom_range(160, 128));
      send_item(rlbc_pkg::OP_FLASH,
                3'($urandom_range(rlbc_pkg::COLOR_RED, rlbc_pkg::COLOR_WHITE)),
                16'd0, 16'd0, count, 16'($urandom));
      repeat (2 * count + 2) send_tick();
   endtask

   function automatic logic [15:0] pick_length();
      case ($urandom_range(19))
         0:       return 16'($urandom);
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(4));
      endcase
   endfunction

   // Commands followed by runs of ticks, with some noise and ignored commands.
   task automatic test_random_traffic(input int target);
      int         useful;
      int         kind;
      logic [1:0] op;
      logic [2:0] colour;
      logic [7:0] count;
      logic [15:0] lvl;
      useful = 0;
      while (useful < target) begin
         kind = $urandom_range(99);
         if (kind < 10) begin
            op = 2'($urandom);
            colour = 3'($urandom);
            if ((op != rlbc_pkg::OP_TICK && colour != rlbc_pkg::COLOR_NONE) ||
                (op == rlbc_pkg::OP_TICK && pat_active))
               useful++;
            send_item(op, colour, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
         end else begin
            op = (kind < 55) ? rlbc_pkg::OP_FLASH :
                 (kind < 80) ? rlbc_pkg::OP_TIMED : rlbc_pkg::OP_STEADY;
            do
               colour = 3'($urandom);
            while (colour == rlbc_pkg::COLOR_NONE);
            if ($urandom_range(19) == 0)
               colour = rlbc_pkg::COLOR_NONE;
            count = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            if (op == rlbc_pkg::OP_STEADY)
               lvl = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
            else
               lvl = pick_length();
            if (colour != rlbc_pkg::COLOR_NONE)
               useful++;
            send_item(op, colour, pick_length(), pick_length(), count, lvl);
            repeat ($urandom_range(14)) begin
               if (pat_active)
                  useful++;
               send_tick();
            end
         end
      end
   endtask

   // Hold the receiver off while items keep coming, so the input stalls.
   task automatic test_backpressure();
      hold_rsp_left = 60;
      send_item(rlbc_pkg::OP_FLASH, rlbc_pkg::COLOR_WHITE, 16'd1, 16'd1, 8'd3, 16'd0);
      repeat (12) send_tick();
   endtask

   // Pause the sender until all results are in, then carry on the pattern.
   task automatic test_drain_pause();
      send_item(rlbc_pkg::OP_TIMED, rlbc_pkg::COLOR_GREEN, 16'd0, 16'd0, 8'd0, 16'd3);
      send_tick();
      wait_all_results();
      repeat (3) send_tick();
   endtask

   task automatic set_idling(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_stall_pct = rsp_pct;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_idle_ticks();
      test_steady();
      test_counted_flash();
      test_endless_flash();
      test_timed_on();
      test_long_count();
      test_random_traffic(80);
      test_backpressure();
      test_drain_pause();

      set_idling(54, 0);
      test_random_traffic(75);
      set_idling(0, 54);
      test_random_traffic(75);
      test_backpressure();
      set_idling(18, 18);
      test_random_traffic(80);
      test_drain_pause();

      wait_all_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && led_expected.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/core/rlbc_pkg.sv
rtl/core/rgb_led_blink_controller_top.sv
dv/tb_rgb_led_blink_controller_top.sv
